### rtl/hds_pkg.sv
package hds_pkg;

    // input item kinds, carried on tuser
    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_INNER = 2'd2;
    localparam logic [1:0] REG_EDGE  = 2'd3;

    // register reset values
    localparam logic [8:0]  ROWS_RST  = 9'd256;
    localparam logic [8:0]  COLS_RST  = 9'd256;
    localparam logic [15:0] INNER_RST = 16'd0;
    localparam logic [15:0] EDGE_RST  = 16'd25600;

    localparam int TEMP_W = 16;
    localparam int DIM_W  = 9;
    // weighted 3x3 sum of 16-bit cells, kernel total 16, plus rounding term
    localparam int SUM_W  = TEMP_W + 4;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_FILL,
        OP_RD,
        OP_SHIFT,
        OP_CALC,
        OP_CELL,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] slot;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

### rtl/hds_regs.sv
module hds_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [8:0]  o_grid_rows,
    output logic [8:0]  o_grid_cols,
    output logic [15:0] o_inner_temp,
    output logic [15:0] o_edge_temp
);

    logic [8:0]  r_grid_rows;
    logic [8:0]  r_grid_cols;
    logic [15:0] r_inner_temp;
    logic [15:0] r_edge_temp;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= hds_pkg::ROWS_RST;
            r_grid_cols  <= hds_pkg::COLS_RST;
            r_inner_temp <= hds_pkg::INNER_RST;
            r_edge_temp  <= hds_pkg::EDGE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                hds_pkg::REG_ROWS:  r_grid_rows  <= pwdata[8:0];
                hds_pkg::REG_COLS:  r_grid_cols  <= pwdata[8:0];
                hds_pkg::REG_INNER: r_inner_temp <= pwdata[15:0];
                hds_pkg::REG_EDGE:  r_edge_temp  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            hds_pkg::REG_ROWS:  prdata = {23'd0, r_grid_rows};
            hds_pkg::REG_COLS:  prdata = {23'd0, r_grid_cols};
            hds_pkg::REG_INNER: prdata = {16'd0, r_inner_temp};
            hds_pkg::REG_EDGE:  prdata = {16'd0, r_edge_temp};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_grid_rows  = r_grid_rows;
    assign o_grid_cols  = r_grid_cols;
    assign o_inner_temp = r_inner_temp;
    assign o_edge_temp  = r_edge_temp;

endmodule

### rtl/hds_dp.sv
module hds_dp #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hds_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_ROWS+1)-1:0]        i_row,
    input  logic [$clog2(MAX_COLS+1)-1:0]        i_col,
    input  logic [$clog2(MAX_COLS+1)-1:0]        i_ld,
    input  logic [7:0]                           i_rd_row,
    input  logic [7:0]                           i_rd_col,
    input  logic [8:0]                           i_grid_rows,
    input  logic [8:0]                           i_grid_cols,
    input  logic [15:0]                          i_inner_temp,
    input  logic [15:0]                          i_edge_temp,
    input  logic                                 i_m_tready,
    output logic [$clog2(MAX_ROWS+1)-1:0]        o_live_rows,
    output logic [$clog2(MAX_COLS+1)-1:0]        o_live_cols,
    output hds_pkg::t_stat                       o_stat,
    output logic                                 o_m_tvalid,
    output logic [31:0]                          o_m_tdata
);

    localparam int DRW = $clog2(MAX_ROWS + 1);
    localparam int DCW = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int AW  = 1 + RW + CW;
    localparam int TW  = hds_pkg::TEMP_W;
    localparam int SW  = hds_pkg::SUM_W;

    function automatic logic [DRW-1:0] clamp_rows(input logic [8:0] v);
        if (v < 9'd3) return DRW'(3);
        if (32'(v) > MAX_ROWS) return DRW'(MAX_ROWS);
        return DRW'(v);
    endfunction

    function automatic logic [DCW-1:0] clamp_cols(input logic [8:0] v);
        if (v < 9'd3) return DCW'(3);
        if (32'(v) > MAX_COLS) return DCW'(MAX_COLS);
        return DCW'(v);
    endfunction

    logic [TW-1:0]  mem [2**AW];
    logic [DRW-1:0] r_live_rows;
    logic [DCW-1:0] r_live_cols;
    logic [TW-1:0]  r_live_edge;
    logic           r_cur;
    logic [15:0]    r_steps;
    logic [TW-1:0]  r_rdata;
    logic [TW-1:0]  r_inc0;
    logic [TW-1:0]  r_inc1;
    logic [TW-1:0]  r_win [3][3];
    logic           r_cell_in;
    logic           r_out_valid;
    logic [TW-1:0]  r_out_cell;
    logic [15:0]    r_out_steps;

    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [TW-1:0]  wr_data;
    logic [RW-1:0]  nb_row;
    logic           ring;
    logic [TW-1:0]  own;
    logic [SW-1:0]  sum;
    logic [TW-1:0]  new_val;
    logic [DRW-1:0] last_row;
    logic [DCW-1:0] last_col;

    assign last_row = r_live_rows - DRW'(1);
    assign last_col = r_live_cols - DCW'(1);

    // read address: neighbor row of the column being loaded, or the cell of a read beat
    assign nb_row = RW'(i_row) + RW'(i_cmd.slot) - RW'(1);
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {r_cur, nb_row, CW'(i_ld)};
        case (i_cmd.op)
            hds_pkg::OP_RD: rd_en = 1'b1;
            hds_pkg::OP_CELL: begin
                rd_en   = 1'b1;
                rd_addr = {r_cur, RW'(i_rd_row), CW'(i_rd_col)};
            end
            default: ;
        endcase
    end

    // 1-2-1 kernel; neighbors off the grid take the cell's own value, and a cell equal to the edge value holds
    assign own = r_win[1][1];
    always_comb begin
        logic [TW-1:0] v;
        logic          ok;
        sum = SW'(8);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ok = !((i == 0 && i_row == '0) || (i == 2 && i_row == last_row) ||
                       (j == 0 && i_col == '0) || (j == 2 && i_col == last_col));
                v  = ok ? r_win[i][j] : own;
                sum = sum + (SW'(v) << ((i == 1 ? 1 : 0) + (j == 1 ? 1 : 0)));
            end
        end
        new_val = (own == r_live_edge) ? own : sum[SW-1:4];
    end

    // outer ring test for the restart fill
    assign ring = (i_row == '0) || (i_col == '0) || (i_row == last_row) || (i_col == last_col);

    // write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {1'b0, RW'(i_row), CW'(i_col)};
        wr_data = ring ? r_live_edge : i_inner_temp;
        case (i_cmd.op)
            hds_pkg::OP_FILL: wr_en = 1'b1;
            hds_pkg::OP_CALC: begin
                wr_en   = 1'b1;
                wr_addr = {~r_cur, RW'(i_row), CW'(i_col)};
                wr_data = new_val;
            end
            default: ;
        endcase
    end

    // grid memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // column capture and window shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == hds_pkg::OP_RD && i_cmd.slot == 2'd1) begin
            r_inc0 <= r_rdata;
        end
        if (i_cmd.op == hds_pkg::OP_RD && i_cmd.slot == 2'd2) begin
            r_inc1 <= r_rdata;
        end
        if (i_cmd.op == hds_pkg::OP_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_inc0;
            r_win[1][2] <= r_inc1;
            r_win[2][2] <= r_rdata;
        end
        if (i_cmd.op == hds_pkg::OP_CELL) begin
            r_cell_in <= (32'(i_rd_row) < 32'(r_live_rows)) &&
                         (32'(i_rd_col) < 32'(r_live_cols));
        end
    end

    // grid size, edge, buffer select and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_rows <= clamp_rows(hds_pkg::ROWS_RST);
            r_live_cols <= clamp_cols(hds_pkg::COLS_RST);
            r_live_edge <= hds_pkg::EDGE_RST;
            r_cur       <= 1'b0;
            r_steps     <= 16'd0;
        end else if (i_cmd.op == hds_pkg::OP_LATCH) begin
            r_live_rows <= clamp_rows(i_grid_rows);
            r_live_cols <= clamp_cols(i_grid_cols);
            r_live_edge <= i_edge_temp;
            r_cur       <= 1'b0;
            r_steps     <= 16'd0;
        end else if (i_cmd.op == hds_pkg::OP_CALC && i_cmd.last) begin
            r_cur <= ~r_cur;
            if (r_steps != 16'hFFFF) begin
                r_steps <= r_steps + 16'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == hds_pkg::OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == hds_pkg::OP_OUT) begin
            r_out_cell  <= r_cell_in ? r_rdata : '0;
            r_out_steps <= r_steps;
        end
    end

    assign o_stat.out_busy = r_out_valid & ~i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {r_out_steps, r_out_cell};
    assign o_live_rows     = r_live_rows;
    assign o_live_cols     = r_live_cols;

endmodule

### rtl/hds_ctrl.sv
module hds_ctrl #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic [1:0]                    i_kind,
    output logic                          o_s_tready,
    input  logic [$clog2(MAX_ROWS+1)-1:0] i_live_rows,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_live_cols,
    input  hds_pkg::t_stat                i_stat,
    output hds_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_ROWS+1)-1:0] o_row,
    output logic [$clog2(MAX_COLS+1)-1:0] o_col,
    output logic [$clog2(MAX_COLS+1)-1:0] o_ld
);

    localparam int DRW = $clog2(MAX_ROWS + 1);
    localparam int DCW = $clog2(MAX_COLS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FILL  = 8'b0000_0010,
        S_RD0   = 8'b0000_0100,
        S_RD1   = 8'b0000_1000,
        S_RD2   = 8'b0001_0000,
        S_SHIFT = 8'b0010_0000,
        S_CALC  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state         r_state, n_state;
    logic [DRW-1:0] r_row, n_row;
    logic [DCW-1:0] r_col, n_col;
    logic [DCW-1:0] r_ld, n_ld;
    logic           accept;
    logic           last_col;
    logic           last_row;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid & o_s_tready;
    assign last_col   = (r_col == i_live_cols - DCW'(1));
    assign last_row   = (r_row == i_live_rows - DRW'(1));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_ld    = r_ld;
        o_cmd   = '{op: hds_pkg::OP_NONE, slot: 2'd0, last: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        hds_pkg::KIND_RESTART: begin
                            o_cmd.op = hds_pkg::OP_LATCH;
                            n_row    = '0;
                            n_col    = '0;
                            n_state  = S_FILL;
                        end
                        hds_pkg::KIND_ADVANCE: begin
                            n_row   = '0;
                            n_ld    = '0;
                            n_state = S_RD0;
                        end
                        hds_pkg::KIND_READ: begin
                            o_cmd.op = hds_pkg::OP_CELL;
                            n_state  = S_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.op = hds_pkg::OP_FILL;
                if (last_col) begin
                    n_col = '0;
                    n_row = r_row + DRW'(1);
                    if (last_row) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_col = r_col + DCW'(1);
                end
            end
            S_RD0: begin
                o_cmd.op   = hds_pkg::OP_RD;
                o_cmd.slot = 2'd0;
                n_state    = S_RD1;
            end
            S_RD1: begin
                o_cmd.op   = hds_pkg::OP_RD;
                o_cmd.slot = 2'd1;
                n_state    = S_RD2;
            end
            S_RD2: begin
                o_cmd.op   = hds_pkg::OP_RD;
                o_cmd.slot = 2'd2;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.op = hds_pkg::OP_SHIFT;
                if (r_ld == '0) begin
                    n_ld    = DCW'(1);
                    n_state = S_RD0;
                end else begin
                    n_col   = r_ld - DCW'(1);
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.op = hds_pkg::OP_CALC;
                if (last_col) begin
                    if (last_row) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_row   = r_row + DRW'(1);
                        n_ld    = '0;
                        n_state = S_RD0;
                    end
                end else begin
                    n_ld    = r_ld + DCW'(1);
                    n_state = ((r_ld + DCW'(1)) < i_live_cols) ? S_RD0 : S_SHIFT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = hds_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_ld    <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_ld    <= n_ld;
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;
    assign o_ld  = r_ld;

    a_calc_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_col < i_live_cols && r_row < i_live_rows))
        else $error("stencil cell outside grid");

    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == hds_pkg::KIND_READ) |=> (r_state == S_OUT))
        else $error("read beat did not reach output state");

    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == hds_pkg::KIND_RESTART) |=> (r_state == S_FILL && r_row == '0))
        else $error("restart beat did not start fill");

    a_load_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> (r_ld < i_live_cols))
        else $error("column load beyond grid");

endmodule

### rtl/heat_diffusion_stencil_3x3.sv
// channel  | dir | handshake                       | payload
// ---------+-----+---------------------------------+-------------------------------------
// s stream | in  | i_s_tvalid / o_s_tready         | tuser kind, tdata row, col
// m stream | out | o_m_tvalid / i_m_tready         | tdata cell_value, steps_done
// apb      | in  | psel, penable, pwrite, pready   | paddr, pwdata, prdata (4 registers)
//
// restart: one cell written per cycle
// advance: the single grid read port fetches each
//   stencil column as three reads before the shift and write of one cell
// read: a grid read, then any wait for the output register to drain
// synchronous active-low reset; grid contents undefined until a restart
// a stalled output beat holds a following read in the output state, nothing is dropped
module heat_diffusion_stencil_3x3 #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // row[7:0], col[15:8]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // cell_value[15:0], steps_done[31:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DRW = $clog2(MAX_ROWS + 1);
    localparam int DCW = $clog2(MAX_COLS + 1);

    logic [8:0]     grid_rows;
    logic [8:0]     grid_cols;
    logic [15:0]    inner_temp;
    logic [15:0]    edge_temp;
    hds_pkg::t_cmd  cmd;
    hds_pkg::t_stat stat;
    logic [DRW-1:0] row;
    logic [DCW-1:0] col;
    logic [DCW-1:0] ld;
    logic [DRW-1:0] live_rows;
    logic [DCW-1:0] live_cols;

    // configuration registers
    hds_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_grid_rows  (grid_rows),
        .o_grid_cols  (grid_cols),
        .o_inner_temp (inner_temp),
        .o_edge_temp  (edge_temp)
    );

    // sweep controller
    hds_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_kind      (i_s_tuser),
        .o_s_tready  (o_s_tready),
        .i_live_rows (live_rows),
        .i_live_cols (live_cols),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_row       (row),
        .o_col       (col),
        .o_ld        (ld)
    );

    // grid memory and stencil datapath
    hds_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_row        (row),
        .i_col        (col),
        .i_ld         (ld),
        .i_rd_row     (i_s_tdata[7:0]),
        .i_rd_col     (i_s_tdata[15:8]),
        .i_grid_rows  (grid_rows),
        .i_grid_cols  (grid_cols),
        .i_inner_temp (inner_temp),
        .i_edge_temp  (edge_temp),
        .i_m_tready   (i_m_tready),
        .o_live_rows  (live_rows),
        .o_live_cols  (live_cols),
        .o_stat       (stat),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

### tb/sv/heat_diffusion_stencil_3x3_tb.sv
module heat_diffusion_stencil_3x3_tb;

    localparam int GRID_MAX = 256;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_PCT = 28;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // row[7:0], col[15:8]
    logic [1:0]  i_s_tuser;   // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // cell_value[15:0], steps_done[31:16]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    heat_diffusion_stencil_3x3 i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [15:0] steps;
        logic [15:0] cell_val;
    } t_cell_read;

    // shadow of the grid and its control state
    logic [15:0] heat [2][GRID_MAX][GRID_MAX];
    bit          cur_buf;
    int unsigned step_cnt;
    logic [8:0]  cfg_rows, cfg_cols;
    logic [15:0] cfg_inner, cfg_edge;
    int unsigned live_rows, live_cols;
    logic [15:0] live_edge;

    t_cell_read read_q[$];
    int unsigned errors;
    int unsigned cycles;
    bit          quiet;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("heat_diffusion_stencil_3x3_tb: done, errors");
            $finish;
        end
    end

    // output side ready with random stalls
    always @(negedge i_clk) begin
        i_m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // check each output beat against the oldest expected read
    always @(posedge i_clk) begin
        t_cell_read want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (read_q.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = read_q.pop_front();
                if (o_m_tdata[15:0] !== want.cell_val) begin
                    $display("%0t cell_value: expected %h, actual %h",
                             $time, want.cell_val, o_m_tdata[15:0]);
                    errors++;
                end
                if (o_m_tdata[31:16] !== want.steps) begin
                    $display("%0t steps_done: expected %h, actual %h",
                             $time, want.steps, o_m_tdata[31:16]);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(logic [8:0] v);
        if (v < 3) return 3;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    // one jacobi step into the other buffer
    task automatic diffuse_step();
        int unsigned own, sum, nv, w;
        int r, c, dr, dc;
        bit dst;
        dst = ~cur_buf;
        for (r = 0; r < live_rows; r++) begin
            for (c = 0; c < live_cols; c++) begin
                own = heat[cur_buf][r][c];
                if (own == live_edge) begin
                    heat[dst][r][c] = own;
                end else begin
                    sum = 0;
                    for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                            if (r + dr >= 0 && r + dr < live_rows &&
                                c + dc >= 0 && c + dc < live_cols)
                                nv = heat[cur_buf][r + dr][c + dc];
                            else
                                nv = own;
                            w = (dr == 0 ? 2 : 1) * (dc == 0 ? 2 : 1);
                            sum += nv * w;
                        end
                    end
                    heat[dst][r][c] = 16'((sum + 8) >> 4);
                end
            end
        end
        cur_buf = dst;
        if (step_cnt < 16'hFFFF) step_cnt++;
    endtask

    // shadow update for one accepted item
    task automatic predict_item(logic [1:0] kind, logic [7:0] row, logic [7:0] col);
        t_cell_read rd;
        int r, c;
        case (kind)
            hds_pkg::KIND_RESTART: begin
                live_rows = clamp_dim(cfg_rows);
                live_cols = clamp_dim(cfg_cols);
                live_edge = cfg_edge;
                for (r = 0; r < live_rows; r++)
                    for (c = 0; c < live_cols; c++)
                        heat[0][r][c] = (r == 0 || c == 0 || r == live_rows - 1 ||
                                         c == live_cols - 1) ? live_edge : cfg_inner;
                cur_buf = 1'b0;
                step_cnt = 0;
            end
            hds_pkg::KIND_ADVANCE: diffuse_step();
            hds_pkg::KIND_READ: begin
                rd.cell_val = (row < live_rows && col < live_cols) ?
                              heat[cur_buf][row][col] : '0;
                rd.steps = step_cnt[15:0];
                read_q.push_back(rd);
            end
            default: ;
        endcase
    endtask

    // send one input beat, with random gaps before it
    task automatic send_beat(logic [1:0] kind, logic [7:0] row, logic [7:0] col);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {col, row};
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(kind, row, col);
    endtask

    // read one cell, wait for every read, then let the block settle
    task automatic drain();
        send_beat(hds_pkg::KIND_READ, 8'd0, 8'd0);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (read_q.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    // apb write, setup then access
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hds_pkg::REG_ROWS:  cfg_rows  = val[8:0];
            hds_pkg::REG_COLS:  cfg_cols  = val[8:0];
            hds_pkg::REG_INNER: cfg_inner = val[15:0];
            default:            cfg_edge  = val[15:0];
        endcase
    endtask

    task automatic set_grid(logic [31:0] rows, logic [31:0] cols,
                            logic [31:0] inner, logic [31:0] edge_t);
        reg_write(hds_pkg::REG_ROWS, rows);
        reg_write(hds_pkg::REG_COLS, cols);
        reg_write(hds_pkg::REG_INNER, inner);
        reg_write(hds_pkg::REG_EDGE, edge_t);
    endtask

    // reset register values, full size grid, corners and far cells
    task automatic test_reset_values();
        send_beat(hds_pkg::KIND_RESTART, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd255, 8'd255);
        send_beat(hds_pkg::KIND_READ, 8'd128, 8'd77);
        drain();
    endtask

    // sizes below and above range, extreme temperatures
    task automatic test_extremes();
        set_grid(32'h0, 32'h1FF, 32'hFFFF, 32'h0);
        send_beat(hds_pkg::KIND_RESTART, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_ADVANCE, 8'hFF, 8'hFF);
        send_beat(hds_pkg::KIND_ADVANCE, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd1, 8'd1);
        send_beat(hds_pkg::KIND_READ, 8'd1, 8'd255);
        send_beat(hds_pkg::KIND_READ, 8'd3, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd2, 8'd128);
        drain();
        // tall grid, zero interior under a hot edge
        set_grid(32'hFFFF_FF00, 32'd3, 32'h0, 32'hFFFF);
        send_beat(hds_pkg::KIND_RESTART, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_ADVANCE, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd255, 8'd1);
        send_beat(hds_pkg::KIND_READ, 8'd1, 8'd1);
        send_beat(hds_pkg::KIND_READ, 8'd128, 8'd3);
        drain();
    endtask

    // interior equal to edge holds, read back at one interior cell
    task automatic test_hold();
        set_grid(32'd5, 32'd4, 32'h1234, 32'h1234);
        send_beat(hds_pkg::KIND_RESTART, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_ADVANCE, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_ADVANCE, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd2, 8'd1);
        send_beat(KIND_UNUSED, 8'hA5, 8'h5A);
        drain();
    endtask

    // register changes after restart wait for the next restart
    task automatic test_late_config();
        set_grid(32'd4, 32'd6, 32'h8000, 32'h0100);
        send_beat(hds_pkg::KIND_RESTART, 8'd0, 8'd0);
        drain();
        set_grid(32'd9, 32'd3, 32'h0042, 32'h8000);
        send_beat(hds_pkg::KIND_ADVANCE, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd1, 8'd4);
        send_beat(hds_pkg::KIND_READ, 8'd4, 8'd1);
        send_beat(hds_pkg::KIND_RESTART, 8'd0, 8'd0);
        send_beat(hds_pkg::KIND_READ, 8'd4, 8'd1);
        drain();
    endtask

    // random settings, each followed by a restart and a random item mix
    task automatic test_random(int rounds, int per_round);
        int n, k, pick;
        logic [15:0] inner, edge_t;
        for (n = 0; n < rounds; n++) begin
            quiet = (n == 1);
            inner = $urandom();
            edge_t = ($urandom_range(3) == 0) ? inner : 16'($urandom());
            set_grid($urandom_range(3, 12) | ($urandom() & 32'hFFFF_FE00),
                     $urandom_range(3, 12), inner, edge_t);
            send_beat(hds_pkg::KIND_RESTART, 8'($urandom()), 8'($urandom()));
            for (k = 0; k < per_round; k++) begin
                pick = $urandom_range(99);
                if (pick < 25)
                    send_beat(hds_pkg::KIND_ADVANCE, 8'($urandom()), 8'($urandom()));
                else if (pick < 85)
                    send_beat(hds_pkg::KIND_READ, 8'($urandom_range(live_rows - 1)),
                              8'($urandom_range(live_cols - 1)));
                else if (pick < 95)
                    send_beat(hds_pkg::KIND_READ, 8'($urandom()), 8'($urandom()));
                else
                    send_beat(KIND_UNUSED, 8'($urandom()), 8'($urandom()));
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = hds_pkg::KIND_RESTART;
        i_m_tready = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cycles     = 0;
        errors     = 0;
        quiet      = 1'b0;
        cur_buf    = 1'b0;
        step_cnt   = 0;
        cfg_rows   = hds_pkg::ROWS_RST;
        cfg_cols   = hds_pkg::COLS_RST;
        cfg_inner  = hds_pkg::INNER_RST;
        cfg_edge   = hds_pkg::EDGE_RST;
        live_rows  = clamp_dim(hds_pkg::ROWS_RST);
        live_cols  = clamp_dim(hds_pkg::COLS_RST);
        live_edge  = hds_pkg::EDGE_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_extremes();
        test_hold();
        test_late_config();
        test_random(4, 15);

        wait (read_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && read_q.size() == 0) begin
            $display("heat_diffusion_stencil_3x3_tb: done, clean");
        end else begin
            $display("heat_diffusion_stencil_3x3_tb: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/hds_pkg.sv
rtl/hds_regs.sv
rtl/hds_dp.sv
rtl/hds_ctrl.sv
rtl/heat_diffusion_stencil_3x3.sv
tb/sv/heat_diffusion_stencil_3x3_tb.sv
